// ===== rtl/core/rs_gf1024_t4_ecc_encoder_top_defines.svh =====
// ---------------------------------------------------------------------------
// rs encoder assertion macros
// shared concurrent assertion forms for the encoder core
// ---------------------------------------------------------------------------
`ifndef RS_GF1024_T4_ECC_ENCODER_TOP_DEFINES_SVH
`define RS_GF1024_T4_ECC_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RSENC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsenc assertion failed");

// next-cycle implication, disabled in reset
`define RSENC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsenc assertion failed");

`endif

// ===== rtl/core/rsenc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsenc_pkg
// field constants, generator coefficients and constant multipliers for the
// gf(2^10) eight-parity reed-solomon encoder
// ---------------------------------------------------------------------------
package rsenc_pkg;

   localparam int SymW    = 10;
   localparam int NPar    = 8;
   localparam int NEcc    = 10;
   localparam int TapW    = $clog2(NPar);
   localparam int CntW    = $clog2(NEcc);
   localparam int DataW   = 8;
   localparam int BufW    = NPar * SymW;

   localparam logic [SymW:0]      FieldPoly = 11'h409;
   localparam logic [CntW-1:0]    LastIdx   = CntW'(NEcc - 1);

   typedef logic [SymW-1:0]            sym_type;
   typedef logic [NPar-1:0][SymW-1:0]  par_vec_type;
   typedef logic [NPar:0][SymW-1:0]    gen_poly_type;
   typedef logic [NPar-1:0][SymW-1:0][SymW-1:0] gen_cols_type;

   typedef struct packed {
      logic        load;
      par_vec_type parity;
   } par_load_type;

   function automatic sym_type gf_mul(sym_type a, sym_type b);
      logic [SymW:0] x;
      sym_type       r;
      x = {1'b0, a};
      r = '0;
      for (int k = 0; k < SymW; k++) begin
         if (b[k]) begin
            r ^= x[SymW-1:0];
         end
         x = {x[SymW-1:0], 1'b0};
         if (x[SymW]) begin
            x ^= FieldPoly;
         end
      end
      return r;
   endfunction

   function automatic gen_poly_type make_gen();
      gen_poly_type g;
      sym_type      root;
      g    = '0;
      g[0] = sym_type'(1);
      root = sym_type'(1);
      for (int i = 1; i <= NPar; i++) begin
         root = gf_mul(root, sym_type'(2));
         for (int j = i; j > 0; j--) begin
            g[j] = g[j-1] ^ gf_mul(g[j], root);
         end
         g[0] = gf_mul(g[0], root);
      end
      return g;
   endfunction

   localparam gen_poly_type GenPoly = make_gen();

   // column k of tap j is g[j] * alpha^k
   function automatic gen_cols_type make_cols();
      gen_cols_type c;
      for (int j = 0; j < NPar; j++) begin
         for (int k = 0; k < SymW; k++) begin
            c[j][k] = gf_mul(GenPoly[j], sym_type'(1) << k);
         end
      end
      return c;
   endfunction

   localparam gen_cols_type GenCols = make_cols();

   // constant multiply as an xor network
   function automatic sym_type tap_mul(logic [TapW-1:0] tap, sym_type fb);
      sym_type r;
      r = '0;
      for (int k = 0; k < SymW; k++) begin
         if (fb[k]) begin
            r ^= GenCols[tap][k];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rsenc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsenc channel interfaces
// valid/ready channels for data requests and ecc responses
// ---------------------------------------------------------------------------
interface rsenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rsenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ecc_byte;
   logic       last_ecc;

   modport source (output valid, output ecc_byte, output last_ecc, input ready);
   modport sink   (input valid, input ecc_byte, input last_ecc, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsenc_lfsr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsenc_lfsr
// request register and eight-stage parity lfsr with constant gf multipliers
// ---------------------------------------------------------------------------
`include "rs_gf1024_t4_ecc_encoder_top_defines.svh"

module rsenc_lfsr (
   input  wire logic           clock,
   input  wire logic           reset,
   rsenc_req_if.sink           req_bus,
   input  wire logic           buf_free,
   output rsenc_pkg::par_load_type par_load
);

   logic                          req_valid_ff, req_valid_in;
   logic [rsenc_pkg::DataW-1:0]   data_ff, data_in;
   logic                          last_ff, last_in;
   rsenc_pkg::par_vec_type        par_ff, par_in;
   rsenc_pkg::par_vec_type        par_next;
   rsenc_pkg::sym_type            fb;
   logic                          consume;
   logic                          req_ready;

   assign consume   = req_valid_ff && (!last_ff || buf_free);
   assign req_ready = !req_valid_ff || consume;
   assign req_bus.ready = req_ready;

   assign fb = {{(rsenc_pkg::SymW - rsenc_pkg::DataW){1'b0}}, data_ff}
               ^ par_ff[rsenc_pkg::NPar-1];

   always_comb begin
      par_next[0] = rsenc_pkg::tap_mul('0, fb);
      for (int j = 1; j < rsenc_pkg::NPar; j++) begin
         par_next[j] = par_ff[j-1] ^ rsenc_pkg::tap_mul(rsenc_pkg::TapW'(j), fb);
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      if (req_ready) begin
         req_valid_in = req_bus.valid;
         data_in      = req_bus.data_byte;
         last_in      = req_bus.last_byte;
      end
   end

   always_comb begin
      par_in = par_ff;
      if (consume) begin
         par_in = last_ff ? '0 : par_next;
      end
   end

   assign par_load.load   = consume && last_ff;
   assign par_load.parity = par_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         par_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         par_ff       <= par_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   // lfsr clears after a chunk closes
   `RSENC_ASSERT_NEXT(a_clear_after_last, clock, reset, consume && last_ff, par_ff == '0)
   // a held request keeps its byte
   `RSENC_ASSERT_NEXT(a_hold_stalled, clock, reset, req_valid_ff && !consume,
      req_valid_ff && $stable(data_ff) && $stable(last_ff))
   // parity only moves on a consumed byte
   `RSENC_ASSERT_NEXT(a_par_stable, clock, reset, !consume, $stable(par_ff))

endmodule
`default_nettype wire

// ===== rtl/core/rsenc_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsenc_pack
// parity snapshot buffer, streams ten packed ecc bytes
// ---------------------------------------------------------------------------
`include "rs_gf1024_t4_ecc_encoder_top_defines.svh"

module rsenc_pack (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rsenc_pkg::par_load_type par_load,
   output logic                    buf_free,
   rsenc_rsp_if.source             rsp_bus
);

   logic [rsenc_pkg::BufW-1:0] buf_ff, buf_in;
   logic [rsenc_pkg::CntW-1:0] count_ff, count_in;
   logic                       valid_ff, valid_in;
   logic                       send;
   logic                       send_last;

   assign send      = valid_ff && rsp_bus.ready;
   assign send_last = send && (count_ff == rsenc_pkg::LastIdx);
   assign buf_free  = !valid_ff || send_last;

   assign rsp_bus.valid    = valid_ff;
   assign rsp_bus.ecc_byte = buf_ff[7:0];
   assign rsp_bus.last_ecc = (count_ff == rsenc_pkg::LastIdx);

   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      if (par_load.load) begin
         // four symbols per group pack little-endian, groups in order
         buf_in   = par_load.parity;
         count_in = '0;
         valid_in = 1'b1;
      end else if (send) begin
         if (send_last) begin
            valid_in = 1'b0;
         end else begin
            buf_in   = {8'h00, buf_ff[rsenc_pkg::BufW-1:8]};
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      buf_ff <= buf_in;
   end

   // no snapshot overwrites undelivered ecc bytes
   `RSENC_ASSERT_NOW(a_load_when_free, clock, reset, par_load.load, buf_free)
   // byte index stays within the ecc block
   `RSENC_ASSERT_NOW(a_count_range, clock, reset, valid_ff, count_ff <= rsenc_pkg::LastIdx)
   // buffer empties after the tenth byte
   `RSENC_ASSERT_NEXT(a_empty_after_last, clock, reset, send_last && !par_load.load,
      !valid_ff)

endmodule
`default_nettype wire

// ===== rtl/core/rs_gf1024_t4_ecc_encoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rs_gf1024_t4_ecc_encoder_top
// shortened reed-solomon encoder, gf(2^10), eight parity symbols
// ---------------------------------------------------------------------------
// One data byte is accepted per clock while no last byte waits, highest
// chunk index first; a byte flagged last_byte closes the chunk. Each byte
// passes a request register and then the parity lfsr, which sustains one
// byte per cycle likewise. On the last byte the eight parity symbols are
// copied into an output buffer and the lfsr clears, so the next chunk
// streams in at once; the ten ecc bytes (four symbols packed little-endian
// into five bytes, twice) leave the buffer one per cycle while the response
// side is ready. The buffer holds one ecc block, so the last byte of a
// following chunk waits until the previous block's tenth byte is taken:
// chunks of ten bytes or more run at full rate while the response is ready.
// ---------------------------------------------------------------------------
module rs_gf1024_t4_ecc_encoder_top (
   input  wire logic   clock,
   input  wire logic   reset,
   rsenc_req_if.sink   req_bus,
   rsenc_rsp_if.source rsp_bus
);

   rsenc_pkg::par_load_type par_load;
   logic                    buf_free;

   rsenc_lfsr u_lfsr (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .buf_free (buf_free),
      .par_load (par_load)
   );

   rsenc_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .par_load (par_load),
      .buf_free (buf_free),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== bench/rs_gf1024_t4_ecc_encoder_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_gf1024_t4_ecc_encoder_checker
// watches the request and response channels, runs its own gf(2^10) parity
// lfsr on every accepted data byte and checks each accepted ecc byte, and
// its last flag, against the oldest predicted byte
// ---------------------------------------------------------------------------
module rs_gf1024_t4_ecc_encoder_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   rsenc_req_if        req_mon,
   rsenc_rsp_if        rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned ecc_outstanding
);

   typedef struct packed {
      logic [rsenc_pkg::DataW-1:0] ecc_byte;
      logic                        last_ecc;
   } ecc_beat_type;

   rsenc_pkg::sym_type     gen_coef [rsenc_pkg::NPar+1];
   rsenc_pkg::par_vec_type lfsr_q;
   ecc_beat_type           pending_ecc_q [$];

   function automatic rsenc_pkg::sym_type gf_times(rsenc_pkg::sym_type a,
                                                   rsenc_pkg::sym_type b);
      rsenc_pkg::sym_type acc;
      rsenc_pkg::sym_type sh;
      acc = '0;
      sh  = a;
      for (int k = 0; k < rsenc_pkg::SymW; k++) begin
         if (b[k]) begin
            acc ^= sh;
         end
         sh = {sh[rsenc_pkg::SymW-2:0], 1'b0}
              ^ (sh[rsenc_pkg::SymW-1] ? rsenc_pkg::FieldPoly[rsenc_pkg::SymW-1:0]
                                       : rsenc_pkg::sym_type'(0));
      end
      return acc;
   endfunction

   // generator roots alpha^1 .. alpha^8
   initial begin : gen_build
      rsenc_pkg::sym_type root;
      for (int i = 0; i <= rsenc_pkg::NPar; i++) begin
         gen_coef[i] = '0;
      end
      gen_coef[0] = rsenc_pkg::sym_type'(1);
      root        = rsenc_pkg::sym_type'(1);
      for (int i = 1; i <= rsenc_pkg::NPar; i++) begin
         root = gf_times(root, rsenc_pkg::sym_type'(2));
         for (int j = i; j > 0; j--) begin
            gen_coef[j] = gen_coef[j-1] ^ gf_times(gen_coef[j], root);
         end
         gen_coef[0] = gf_times(gen_coef[0], root);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ecc check: %s got %0h want %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic shift_in_byte(input logic [rsenc_pkg::DataW-1:0] d, input logic last);
      rsenc_pkg::sym_type         fb;
      logic [rsenc_pkg::BufW-1:0] flat;
      fb = rsenc_pkg::sym_type'(d) ^ lfsr_q[rsenc_pkg::NPar-1];
      for (int j = rsenc_pkg::NPar - 1; j > 0; j--) begin
         lfsr_q[j] = lfsr_q[j-1] ^ gf_times(gen_coef[j], fb);
      end
      lfsr_q[0] = gf_times(gen_coef[0], fb);
      if (last) begin
         // eight symbols packed little-endian give the ten ecc bytes in order
         flat = lfsr_q;
         for (int k = 0; k < rsenc_pkg::NEcc; k++) begin
            pending_ecc_q.push_back('{ecc_byte: flat[8*k +: 8],
                                      last_ecc: (k == rsenc_pkg::NEcc - 1)});
         end
         lfsr_q = '0;
      end
   endtask

   always @(posedge clock) begin
      ecc_beat_type want;
      if (reset) begin
         lfsr_q = '0;
         pending_ecc_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_ecc_q.size() == 0) begin
               report_mismatch("unexpected ecc_byte", int'(rsp_mon.ecc_byte), 0);
            end else begin
               want = pending_ecc_q.pop_front();
               if (rsp_mon.ecc_byte !== want.ecc_byte) begin
                  report_mismatch("ecc_byte", int'(rsp_mon.ecc_byte),
                                  int'(want.ecc_byte));
               end
               if (rsp_mon.last_ecc !== want.last_ecc) begin
                  report_mismatch("last_ecc", int'(rsp_mon.last_ecc),
                                  int'(want.last_ecc));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            shift_in_byte(req_mon.data_byte, req_mon.last_byte);
         end
      end
      ecc_outstanding = int'(pending_ecc_q.size());
   end

endmodule

// ===== bench/rs_gf1024_t4_ecc_encoder_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rs_gf1024_t4_ecc_encoder_top_tb
// streams data chunks of assorted lengths into the encoder in random bursts
// while the response side stalls in changing patterns; the checker predicts
// and compares every ecc byte and this module gives the verdict
// ---------------------------------------------------------------------------
module rs_gf1024_t4_ecc_encoder_top_tb;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   localparam int RandomItems = 480;

   logic           clock = 1'b0;
   logic           reset;
   int unsigned    ecc_mismatches;
   int unsigned    ecc_pending;
   int unsigned    burst_left;
   int unsigned    items_sent;
   bit             drained_midway;
   stall_mode_type stall_mode;
   int unsigned    stall_phase_left;

   rsenc_req_if req_bus ();
   rsenc_rsp_if rsp_bus ();

   rs_gf1024_t4_ecc_encoder_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rs_gf1024_t4_ecc_encoder_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatch_count  (ecc_mismatches),
      .ecc_outstanding (ecc_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // response side stall pattern
   initial begin
      rsp_bus.ready    = 1'b0;
      stall_mode       = STALL_NONE;
      stall_phase_left = 0;
   end

   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       <= stall_mode_type'($urandom_range(0, 2));
         stall_phase_left <= $urandom_range(16, 96);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_bus.ready <= 1'b1;
         end
         STALL_LIGHT: begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // called at a rising edge, returns at the edge that accepts the request
   task automatic send_byte(input logic [7:0] d, input logic l);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= d;
      req_bus.last_byte <= l;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic drain_ecc();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ecc_pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_paced(input logic [7:0] d, input logic l);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 20);
      end
      burst_left--;
      send_byte(d, l);
   endtask

   function automatic logic [7:0] pick_data();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return 8'h00;
      end else if (sel == 1) begin
         return 8'hFF;
      end
      return 8'($urandom);
   endfunction

   initial begin
      int unsigned chunk_len;
      int unsigned sel;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      reset             = 1'b1;
      burst_left        = 0;
      items_sent        = 0;
      drained_midway    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-byte chunks at the field extremes, back to back
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b1);
      // leading zero bytes ahead of the data
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      // short chunks of five and six bytes
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b1);
      drain_ecc();

      items_sent = 0;
      while (items_sent < RandomItems) begin
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            chunk_len = $urandom_range(1, 24);
         end else if (sel < 9) begin
            chunk_len = $urandom_range(25, 80);
         end else begin
            chunk_len = $urandom_range(1, 3);
         end
         for (int i = 1; i <= chunk_len; i++) begin
            send_paced(pick_data(), (i == chunk_len));
         end
         if (!drained_midway && items_sent >= RandomItems / 2) begin
            drained_midway = 1'b1;
            drain_ecc();
            burst_left = 0;
         end
      end

      drain_ecc();
      repeat (20) @(posedge clock);
      if (ecc_mismatches == 0 && ecc_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
